// ===== sv/mt19937_generator_assert.svh =====
// Assertion macros shared by the MT19937 generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MT19937_GENERATOR_ASSERT_SVH
`define MT19937_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mtg_pkg.sv =====
// Shared types and constants of the MT19937 generator.
// Used by the front queue, the back sequencer and the top level.
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int WORD_W       = 32;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int POS_W        = $clog2(STATE_WORDS + 1);
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
	localparam int SEED_SHIFT = 30;

	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_RESEED = 1'b1;

	typedef struct packed {
		logic              reseed;
		logic [WORD_W-1:0] seed;
	} cmd_t;

endpackage

// ===== sv/mt19937_generator.sv =====
// Top level of the MT19937 32-bit random word generator.
// Depends on mtg_pkg, mtg_front, mtg_back and mtg_ram.
//
//   channel   handshake             payload
//   input     in_valid/in_ready     action, seed
//   output    out_valid/out_ready   random_word
//
// A draw inside the state reads the state RAM, then tempers the word into the output register.
// A reseed writes the seed into word 0; each further word passes the registered multiplier.
// A draw at the end of the state first twists (one set-up read, then one word a cycle);
// a draw before any seed also seeds with 5489 first.
// Reset leaves the state unseeded with the position at the end; the RAM is not cleared.
// A full output register holds the sequencer; the input queue fills, then in_ready drops.
module mt19937_generator #(
	parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [mtg_pkg::WORD_W-1:0]  seed,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mtg_pkg::WORD_W-1:0]  random_word
);

	logic          cmd_valid;
	logic          cmd_ready;
	mtg_pkg::cmd_t cmd;

	mtg_front #(
		.QDEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.seed      (seed),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	mtg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word)
	);

endmodule

// ===== sv/mtg_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds the generator state words.
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== sv/mtg_front.sv =====
// Input side of the MT19937 generator: accepts items, tags them as draw or
// reseed and queues them for the back sequencer. Depends on mtg_pkg.
module mtg_front #(
	parameter int QDEPTH = mtg_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [mtg_pkg::WORD_W-1:0]  seed,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output mtg_pkg::cmd_t               cmd
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	mtg_pkg::cmd_t     fifo_q [QDEPTH];
	mtg_pkg::cmd_t     new_cmd;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// The seed field only matters for a reseed item.
	always_comb begin
		new_cmd.reseed = (action == mtg_pkg::ACT_RESEED);
		new_cmd.seed   = (action == mtg_pkg::ACT_RESEED) ? seed : '0;
	end

	assign in_ready  = (count_q != CNT_W'(QDEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// ===== sv/mtg_back.sv =====
// Back sequencer of the MT19937 generator: seeding, twisting, tempering and
// the output register. Depends on mtg_pkg, mtg_ram and the assertion header.
`include "mt19937_generator_assert.svh"

module mtg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  mtg_pkg::cmd_t               cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mtg_pkg::WORD_W-1:0]  random_word
);

	localparam int WW = mtg_pkg::WORD_W;
	localparam int AW = mtg_pkg::ADDR_W;
	localparam int PW = mtg_pkg::POS_W;
	localparam logic [PW-1:0] LAST_IDX = PW'(mtg_pkg::STATE_WORDS - 1);
	localparam logic [PW-1:0] END_POS  = PW'(mtg_pkg::STATE_WORDS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SMUL = 3'd1;
	localparam logic [2:0] S_SADD = 3'd2;
	localparam logic [2:0] S_TPRE = 3'd3;
	localparam logic [2:0] S_TW   = 3'd4;
	localparam logic [2:0] S_RD   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]    state_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] idx_q;
	logic          seeded_q;
	logic          pending_q;
	logic          tw_v_q;
	logic          out_valid_q;

	logic [WW-1:0] prev_q;
	logic [WW-1:0] prod_q;
	logic [WW-1:0] cur_q;
	logic [PW-1:0] widx_q;
	logic [WW-1:0] word_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [WW-1:0] wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [WW-1:0] rdata_a;
	logic [WW-1:0] rdata_b;

	logic          start_seed;
	logic [WW-1:0] seed_val;
	logic          direct_draw;
	logic          tw_issue;
	logic [AW-1:0] nxt_addr;
	logic [AW:0]   far_sum;
	logic [AW-1:0] far_addr;
	logic [WW-1:0] seed_mix;
	logic [WW-1:0] seed_word;
	logic [WW-1:0] tw_y;
	logic [WW-1:0] tw_word;
	logic          out_load;

	function automatic logic [WW-1:0] temper(input logic [WW-1:0] x);
		logic [WW-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	mtg_ram #(
		.WIDTH (WW),
		.DEPTH (mtg_pkg::STATE_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign cmd_ready = (state_q == S_IDLE);

	// A draw goes straight to the output when the state is seeded and the
	// position still points inside it.
	assign direct_draw = !cmd.reseed && seeded_q && (pos_q != END_POS);
	assign start_seed  = cmd_valid && cmd_ready && (cmd.reseed || !seeded_q);
	assign seed_val    = cmd.reseed ? cmd.seed : mtg_pkg::DEFAULT_SEED;

	assign seed_mix  = prev_q ^ (prev_q >> mtg_pkg::SEED_SHIFT);
	assign seed_word = prod_q + WW'(idx_q);

	// Twist addressing: the neighbor wraps to word 0, the far word wraps past
	// the end of the state.
	assign tw_issue = (idx_q != END_POS);
	assign nxt_addr = (idx_q == LAST_IDX) ? '0 : idx_q[AW-1:0] + AW'(1);
	assign far_sum  = {1'b0, idx_q[AW-1:0]} + (AW+1)'(mtg_pkg::SHIFT_OFFSET);
	assign far_addr = (far_sum >= (AW+1)'(mtg_pkg::STATE_WORDS))
		? AW'(far_sum - (AW+1)'(mtg_pkg::STATE_WORDS)) : far_sum[AW-1:0];

	assign tw_y    = {cur_q[WW-1], rdata_a[WW-2:0]};
	assign tw_word = rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_MATRIX : '0);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		we      = 1'b0;
		waddr   = idx_q[AW-1:0];
		wdata   = seed_word;
		raddr_a = pos_q[AW-1:0];
		raddr_b = far_addr;
		unique case (state_q)
			S_IDLE: begin
				if (start_seed) begin
					we    = 1'b1;
					waddr = '0;
					wdata = seed_val;
				end
			end
			S_SADD: begin
				we = 1'b1;
			end
			S_TPRE: begin
				raddr_a = '0;
			end
			S_TW: begin
				we      = tw_v_q;
				waddr   = widx_q[AW-1:0];
				wdata   = tw_word;
				raddr_a = nxt_addr;
			end
			S_SMUL, S_RD, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= END_POS;
			idx_q       <= '0;
			seeded_q    <= 1'b0;
			pending_q   <= 1'b0;
			tw_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (start_seed) begin
							pending_q <= !cmd.reseed;
							idx_q     <= PW'(1);
							state_q   <= S_SMUL;
						end else if (direct_draw) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_TPRE;
						end
					end
				end
				S_SMUL: begin
					state_q <= S_SADD;
				end
				S_SADD: begin
					if (idx_q == LAST_IDX) begin
						seeded_q <= 1'b1;
						pos_q    <= END_POS;
						state_q  <= pending_q ? S_TPRE : S_IDLE;
					end else begin
						idx_q   <= idx_q + PW'(1);
						state_q <= S_SMUL;
					end
				end
				S_TPRE: begin
					idx_q   <= '0;
					tw_v_q  <= 1'b0;
					state_q <= S_TW;
				end
				S_TW: begin
					tw_v_q <= tw_issue;
					if (tw_issue) begin
						idx_q <= idx_q + PW'(1);
					end
					if (tw_v_q && (widx_q == LAST_IDX)) begin
						pos_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						pos_q   <= pos_q + PW'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			prev_q <= seed_val;
		end else if (state_q == S_SADD) begin
			prev_q <= seed_word;
		end
		if (state_q == S_SMUL) begin
			prod_q <= seed_mix * mtg_pkg::INIT_MULT;
		end
		// The neighbor word read for one index is the current word of the next.
		if (state_q == S_TW) begin
			cur_q  <= rdata_a;
			widx_q <= idx_q;
		end
		if (out_load) begin
			word_q <= temper(rdata_a);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = word_q;

	`MTG_ASSERT_IMPL(a_twist_no_overlap, clk, arst_n,
		state_q == S_TW && tw_v_q && tw_issue,
		waddr != raddr_a && waddr != raddr_b, "twist write overlaps a twist read")
	`MTG_ASSERT_IMPL(a_out_pos_inside, clk, arst_n, state_q == S_OUT,
		pos_q < END_POS, "output taken from a position past the state")
	`MTG_ASSERT_NEXT(a_seed_done, clk, arst_n, state_q == S_SADD && idx_q == LAST_IDX,
		seeded_q && pos_q == END_POS, "seeding did not leave the state seeded")
	`MTG_ASSERT_NEXT(a_twist_done, clk, arst_n,
		state_q == S_TW && tw_v_q && widx_q == LAST_IDX,
		state_q == S_RD && pos_q == '0, "twist did not restart the position")

endmodule

// ===== tb/mt19937_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the MT19937 random word generator, top mt19937_generator.
// Depends on mtg_pkg; expected words come from a predictor that runs alongside the stimulus.
module mt19937_generator_test;

	localparam int RANDOM_ITEMS = 1950;
	localparam int DIR_ROWS     = 16;
	localparam int LONG_HOLD    = 1500;
	localparam int DRAIN_CYCLES = 1500;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       action = mtg_pkg::ACT_DRAW;
	logic [mtg_pkg::WORD_W-1:0] seed = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [mtg_pkg::WORD_W-1:0] random_word;

	mt19937_generator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.seed        (seed),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: twister words, read position and seeded flag.
	logic [mtg_pkg::WORD_W-1:0] mt_state [mtg_pkg::STATE_WORDS];
	int unsigned                mt_pos = mtg_pkg::STATE_WORDS;
	bit                         mt_seeded = 1'b0;

	logic [mtg_pkg::WORD_W-1:0] pending_words [$];
	int                         error_count = 0;
	int                         items_offered = 0;
	int                         sender_idle_pct = 24;
	int                         recv_idle_pct = 71;
	bit                         hold_req = 1'b0;

	function automatic void mt_seed(input logic [mtg_pkg::WORD_W-1:0] s);
		logic [mtg_pkg::WORD_W-1:0] prev;
		mt_state[0] = s;
		for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
			prev = mt_state[i-1];
			mt_state[i] = mtg_pkg::INIT_MULT * (prev ^ (prev >> mtg_pkg::SEED_SHIFT)) +
			              mtg_pkg::WORD_W'(i);
		end
		mt_pos = mtg_pkg::STATE_WORDS;
		mt_seeded = 1'b1;
	endfunction

	function automatic void mt_twist();
		logic [mtg_pkg::WORD_W-1:0] y;
		logic [mtg_pkg::WORD_W-1:0] v;
		for (int i = 0; i < mtg_pkg::STATE_WORDS; i++) begin
			y = (mt_state[i] & 32'h8000_0000) |
			    (mt_state[(i + 1) % mtg_pkg::STATE_WORDS] & 32'h7FFF_FFFF);
			v = mt_state[(i + mtg_pkg::SHIFT_OFFSET) % mtg_pkg::STATE_WORDS] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ mtg_pkg::TWIST_MATRIX;
			end
			mt_state[i] = v;
		end
		mt_pos = 0;
	endfunction

	function automatic logic [mtg_pkg::WORD_W-1:0] mt_temper(
			input logic [mtg_pkg::WORD_W-1:0] w);
		logic [mtg_pkg::WORD_W-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [mtg_pkg::WORD_W-1:0] mt_next_word();
		logic [mtg_pkg::WORD_W-1:0] w;
		if (!mt_seeded) begin
			mt_seed(mtg_pkg::DEFAULT_SEED);
		end
		if (mt_pos >= mtg_pkg::STATE_WORDS) begin
			mt_twist();
		end
		w = mt_temper(mt_state[mt_pos]);
		mt_pos++;
		return w;
	endfunction

	function automatic logic [mtg_pkg::WORD_W-1:0] pick_seed();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return mtg_pkg::DEFAULT_SEED;
			default: return $urandom();
		endcase
	endfunction

	// Offers one item, waits for acceptance and records the word that a draw should produce.
	task automatic send_item(input logic act, input logic [mtg_pkg::WORD_W-1:0] seed_value,
	                         input bit known, input logic [mtg_pkg::WORD_W-1:0] known_word);
		logic [mtg_pkg::WORD_W-1:0] predicted;
		if (items_offered < 675) begin
			sender_idle_pct = 24;
			recv_idle_pct = 71;
		end else if (items_offered < 1325) begin
			sender_idle_pct = 71;
			recv_idle_pct = 24;
		end else begin
			sender_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		seed <= seed_value;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		items_offered++;
		if (act == mtg_pkg::ACT_RESEED) begin
			mt_seed(seed_value);
		end else begin
			predicted = mt_next_word();
			pending_words.push_back(known ? known_word : predicted);
		end
	endtask

	typedef struct packed {
		logic                       act;
		logic [mtg_pkg::WORD_W-1:0] seed_value;
		logic                       known;
		logic [mtg_pkg::WORD_W-1:0] word;
	} stim_row_t;

	// The first words of the default sequence are well known; other rows go to the predictor.
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{mtg_pkg::ACT_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd3499211612},
		'{mtg_pkg::ACT_DRAW,   32'h0000_0000, 1'b1, 32'd581869302},
		'{mtg_pkg::ACT_DRAW,   32'h1234_5678, 1'b1, 32'd3890346734},
		'{mtg_pkg::ACT_RESEED, 32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::ACT_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::ACT_RESEED, 32'd5489,      1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'd12345,     1'b1, 32'd3499211612},
		'{mtg_pkg::ACT_DRAW,   32'hA5A5_A5A5, 1'b1, 32'd581869302},
		'{mtg_pkg::ACT_RESEED, 32'h0000_0001, 1'b0, 32'h0},
		'{mtg_pkg::ACT_RESEED, 32'h8000_0000, 1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'h5A5A_5A5A, 1'b0, 32'h0},
		'{mtg_pkg::ACT_RESEED, 32'd5489,      1'b0, 32'h0},
		'{mtg_pkg::ACT_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd3499211612}
	};

	// Output side: checks each accepted word and drives out_ready.
	initial begin
		int hold_left;
		logic [mtg_pkg::WORD_W-1:0] expected;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected random_word, expected none, actual %h",
					         $time, random_word);
					error_count++;
				end else begin
					expected = pending_words.pop_front();
					if (random_word !== expected) begin
						$display("%0t: random_word mismatch, expected %h, actual %h",
						         $time, expected, random_word);
						error_count++;
					end
				end
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int sent;
		int draws;
		bit first_run;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(dir_rows[r].act, dir_rows[r].seed_value, dir_rows[r].known,
			          dir_rows[r].word);
		end

		// Runs of draws between reseeds; the first run is long enough to cross a twist.
		sent = 0;
		first_run = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (!first_run) begin
				send_item(mtg_pkg::ACT_RESEED, pick_seed(), 1'b0, '0);
				sent++;
			end
			if (first_run) begin
				draws = 700;
			end else if ($urandom_range(3) == 0) begin
				draws = $urandom_range(900, 630);
			end else begin
				draws = $urandom_range(60, 0);
			end
			for (int k = 0; k < draws && sent < RANDOM_ITEMS; k++) begin
				if (sent == 100) begin
					hold_req = 1'b1;
				end
				send_item(mtg_pkg::ACT_DRAW, $urandom(), 1'b0, '0);
				sent++;
			end
			first_run = 1'b0;
		end
		in_valid <= 1'b0;

		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(300_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
